// File: src/rc_pkg.sv
// Shared constants, types and helper functions for the radix converter.
package rc_pkg;

  // Default sizing
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int RESULT_CAP     = 32;

  // Register widths and indexes
  localparam int BASE_W = 5;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam logic CFG_IN_BASE  = 1'b0;
  localparam logic CFG_OUT_BASE = 1'b1;
  localparam logic [BASE_W-1:0] IN_BASE_RST  = 5'd10;
  localparam logic [BASE_W-1:0] OUT_BASE_RST = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] TEN        = 8'd10;
  localparam logic [CHAR_W-1:0] LETTER_OFS = CHAR_A - TEN;

  // Commands from controller to datapath
  typedef struct packed {
    logic fold;       // fold the accepted character into the accumulator
    logic start;      // latch the value and start the conversion
    logic div_step;   // one restoring division bit
    logic div_store;  // final bit: store the remainder digit
    logic rd;         // read the next digit to emit
    logic load_out;   // load the output register
    logic advance;    // output transaction done, step to the next digit
  } rc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;    // current division is on its last bit
    logic quot_zero;   // quotient after this bit is zero
    logic final_digit; // digit being emitted is the least significant
  } rc_stat_t;

  // Force a base register into 2..16
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // Map a digit 0..15 to '0'..'9','A'..'F'
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if ({4'd0, d} < TEN) r = CHAR_ZERO + {4'd0, d};
    else r = LETTER_OFS + {4'd0, d};
    return r;
  endfunction

endpackage

// File: src/rc_dp.sv
// Datapath of the radix converter: accumulator, bit-serial divider, digit memory, output register.
module rc_dp #(
  parameter int VALUE_BITS = rc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [rc_pkg::BASE_W-1:0]   cfg_data,
  input  logic [rc_pkg::CHAR_W-1:0]   in_char,
  input  rc_pkg::rc_cmd_t             cmd,
  output rc_pkg::rc_stat_t            stat,
  output logic [rc_pkg::CHAR_W-1:0]   out_char,
  output logic                        out_last,
  output logic                        out_ovf
);

  localparam int DIGIT_CAP = (MAX_DIGITS < rc_pkg::RESULT_CAP) ? MAX_DIGITS : rc_pkg::RESULT_CAP;
  localparam int AW  = $clog2(DIGIT_CAP);
  localparam int CW  = $clog2(DIGIT_CAP + 1);
  localparam int BW  = $clog2(VALUE_BITS);
  localparam int PW  = VALUE_BITS + rc_pkg::BASE_W;
  localparam int SW  = PW + 1;
  localparam int DW  = rc_pkg::DIGIT_W;

  logic [rc_pkg::BASE_W-1:0] in_base_r, out_base_r;
  logic [VALUE_BITS-1:0]     acc_r, acc_nxt;
  logic                      ovf_seen_r;
  logic                      res_ovf_r;
  logic [VALUE_BITS-1:0]     val_r, val_nxt;
  logic [DW-1:0]             rem_r, rem_nxt;
  logic [BW-1:0]             bit_cnt_r;
  logic [CW-1:0]             cnt_r;
  logic [DW-1:0]             digit_mem [DIGIT_CAP];
  logic [DW-1:0]             rd_data_r;
  logic [rc_pkg::CHAR_W-1:0] out_char_r;
  logic                      out_last_r, out_ovf_r;

  logic [rc_pkg::BASE_W-1:0] in_base_eff, out_base_eff;
  logic                      neg;
  logic [rc_pkg::CHAR_W-1:0] mag;
  logic [PW-1:0]             prod;
  logic [SW-1:0]             sum;
  logic [PW-1:0]             diff;
  logic                      fold_ovf;
  logic [rc_pkg::BASE_W-1:0] trial;
  logic                      ge;
  logic [CW-1:0]             rd_idx;

  assign in_base_eff  = rc_pkg::clamp_base(in_base_r);
  assign out_base_eff = rc_pkg::clamp_base(out_base_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_base_r  <= rc_pkg::IN_BASE_RST;
      out_base_r <= rc_pkg::OUT_BASE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == rc_pkg::CFG_IN_BASE) in_base_r <= cfg_data;
      else out_base_r <= cfg_data;
    end
  end

  // Decode the character into a signed digit value
  always_comb begin
    neg = 1'b0;
    mag = '0;
    if (in_char >= rc_pkg::CHAR_ZERO && in_char <= rc_pkg::CHAR_NINE) begin
      mag = in_char - rc_pkg::CHAR_ZERO;
    end else if (in_char >= rc_pkg::LETTER_OFS) begin
      mag = in_char - rc_pkg::LETTER_OFS;
    end else begin
      neg = 1'b1;
      mag = rc_pkg::LETTER_OFS - in_char;
    end
  end

  // Multiply-add with overflow detection
  always_comb begin
    prod = PW'(acc_r) * PW'(in_base_eff);
    sum  = SW'(prod) + SW'(mag);
    diff = prod - PW'(mag);
    if (|prod[PW-1:VALUE_BITS]) fold_ovf = 1'b1;
    else if (neg) fold_ovf = (prod < PW'(mag));
    else fold_ovf = |sum[SW-1:VALUE_BITS];
    acc_nxt = neg ? diff[VALUE_BITS-1:0] : sum[VALUE_BITS-1:0];
  end

  // One restoring division bit by the output base
  always_comb begin
    trial   = {rem_r, val_r[VALUE_BITS-1]};
    ge      = (trial >= out_base_eff);
    rem_nxt = ge ? DW'(trial - out_base_eff) : DW'(trial);
    val_nxt = {val_r[VALUE_BITS-2:0], ge};
  end

  assign rd_idx = cnt_r - CW'(1);

  assign stat.div_done    = (bit_cnt_r == '0);
  assign stat.quot_zero   = (val_nxt == '0);
  assign stat.final_digit = (cnt_r == CW'(1));

  // Accumulator, divider and digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      ovf_seen_r <= 1'b0;
      res_ovf_r  <= 1'b0;
      rem_r      <= '0;
      bit_cnt_r  <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.fold && cmd.start) begin
        acc_r      <= '0;
        ovf_seen_r <= 1'b0;
        res_ovf_r  <= ovf_seen_r | fold_ovf;
        val_r      <= acc_nxt;
        rem_r      <= '0;
        bit_cnt_r  <= BW'(VALUE_BITS - 1);
      end else if (cmd.fold) begin
        acc_r      <= acc_nxt;
        ovf_seen_r <= ovf_seen_r | fold_ovf;
      end
      if (cmd.div_step) begin
        val_r <= val_nxt;
        if (cmd.div_store) begin
          rem_r     <= '0;
          bit_cnt_r <= BW'(VALUE_BITS - 1);
          if (cnt_r < CW'(DIGIT_CAP)) cnt_r <= cnt_r + CW'(1);
          else res_ovf_r <= 1'b1;
        end else begin
          rem_r     <= rem_nxt;
          bit_cnt_r <= bit_cnt_r - BW'(1);
        end
      end
      if (cmd.advance) cnt_r <= cnt_r - CW'(1);
    end
  end

  // Digit memory: write on store, registered read
  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_store && cnt_r < CW'(DIGIT_CAP)) begin
      digit_mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
    if (cmd.rd) rd_data_r <= digit_mem[rd_idx[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_char_r <= rc_pkg::digit_to_char(rd_data_r);
      out_last_r <= (cnt_r == CW'(1));
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_char = out_char_r;
  assign out_last = out_last_r;
  assign out_ovf  = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DIGIT_CAP))
    else $error("digit count beyond capacity");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> {1'b0, rem_r} < out_base_eff)
    else $error("division remainder not below base");

  a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && cmd.div_store && cnt_r < CW'(DIGIT_CAP)) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("stored digit not counted");
`endif

endmodule

// File: src/rc_ctrl.sv
// Controller of the radix converter: sequences accumulate, divide and emit.
module rc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rc_pkg::rc_stat_t  stat,
  output rc_pkg::rc_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_WAIT);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.fold = 1'b1;
          if (in_tlast) begin
            cmd.start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_store = stat.div_done;
        if (stat.div_done && stat.quot_zero) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (out_tready) begin
          cmd.advance = 1'b1;
          state_nxt   = stat.final_digit ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && !out_tready) |=> state_r == S_WAIT)
    else $error("result dropped under stall");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> state_r == S_DIV)
    else $error("last character did not start conversion");
`endif

endmodule

// File: src/radix_converter.sv
// Radix converter top level: digit stream in one base to digit stream in another.
//
// Input channel (in_*): one ASCII character per transaction, most significant
// first; in_tlast marks the final character of a number. Each non-final
// character is folded into the accumulator in the cycle it is accepted, so
// a number streams in at one character per cycle.
// On the final character the input closes (in_tready low) while the value is
// converted by a bit-serial restoring divider, one value bit per step; the
// last step of each output digit stores the digit. Digits are then emitted
// most significant first, each by memory read, output load and transaction,
// the last step waiting for the receiver. out_tlast marks the least
// significant digit and out_tuser carries the sticky overflow flag.
// A zero value gives a single '0'. At most min(MAX_DIGITS, 32) digits leave.
// When the receiver stalls, the output register holds its digit and the
// sequence waits. The configuration port writes the input and output bases
// (index 0 and 1); write it only while no number is in flight.
// Synchronous active-low reset sets bases to 10 and 2 and clears the
// accumulator, overflow flag and digit count; no clearing pass is needed.
module radix_converter #(
  parameter int VALUE_BITS = rc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rc_pkg::MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [rc_pkg::BASE_W-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] digit_char
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [7:0] out_char
  output logic                      out_tlast,
  output logic                      out_tuser   // [0] overflow
);

  rc_pkg::rc_cmd_t  cmd;
  rc_pkg::rc_stat_t stat;

  rc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_char   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

endmodule

// File: test/tb_radix_converter.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_converter: digit-stream driver, digit monitor and predictor.
module tb_radix_converter;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS = 270;
  localparam int DIGIT_LIMIT = (rc_pkg::MAX_DIGITS_DEF < rc_pkg::RESULT_CAP) ?
                               rc_pkg::MAX_DIGITS_DEF : rc_pkg::RESULT_CAP;
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AFTER_BEATS = 200;

  typedef struct packed {
    logic [rc_pkg::CHAR_W-1:0] code;
    logic                      final_char;
  } char_item_t;

  typedef struct packed {
    logic [rc_pkg::CHAR_W-1:0] code;
    logic                      last_digit;
    logic                      overflow;
  } out_digit_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic                      cfg_index = rc_pkg::CFG_IN_BASE;
  logic [rc_pkg::BASE_W-1:0] cfg_data = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = '0;   // [7:0] digit_char
  logic                      in_tlast = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [7:0]                out_tdata;       // [7:0] out_char
  logic                      out_tlast;
  logic                      out_tuser;       // [0] overflow

  // Predictor state: bases as last written, running value and its sticky wrap flag
  logic [rc_pkg::BASE_W-1:0]         in_base_q = rc_pkg::IN_BASE_RST;
  logic [rc_pkg::BASE_W-1:0]         out_base_q = rc_pkg::OUT_BASE_RST;
  logic [rc_pkg::VALUE_BITS_DEF-1:0] acc_q = '0;
  logic                              wrap_q = 1'b0;

  char_item_t char_queue[$];
  out_digit_t digits_due[$];
  out_digit_t want;
  char_item_t next_item;

  int  errors = 0;
  int  items_queued = 0;
  int  chars_pending = 0;
  int  out_beats = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always #5 clk = ~clk;

  radix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Effective radix of a base register: out-of-range values saturate to 2..16
  function automatic int eff_base(input logic [rc_pkg::BASE_W-1:0] b);
    if (b < rc_pkg::BASE_MIN) return int'(rc_pkg::BASE_MIN);
    if (b > rc_pkg::BASE_MAX) return int'(rc_pkg::BASE_MAX);
    return int'(b);
  endfunction

  // Fold one character into the value; on the final one, queue its digits in out_base
  function automatic void fold_and_convert(input logic [rc_pkg::CHAR_W-1:0] c,
                                           input logic lst);
    longint                     value;
    longint                     exact;
    longint                     rest;
    int                         ob;
    int                         n;
    logic                       dropped;
    logic [rc_pkg::DIGIT_W-1:0] rem [DIGIT_LIMIT];
    out_digit_t                 od;
    if (c >= rc_pkg::CHAR_ZERO && c <= rc_pkg::CHAR_NINE) begin
      value = longint'(c) - longint'(rc_pkg::CHAR_ZERO);
    end else begin
      value = longint'(c) - longint'(rc_pkg::CHAR_A) + longint'(rc_pkg::TEN);
    end
    exact = longint'(acc_q) * eff_base(in_base_q) + value;
    // wrap below zero or past the value width
    if (exact < 0 || exact >= (longint'(1) << rc_pkg::VALUE_BITS_DEF)) wrap_q = 1'b1;
    acc_q = exact[rc_pkg::VALUE_BITS_DEF-1:0];
    if (!lst) return;
    ob = eff_base(out_base_q);
    rest = longint'(acc_q);
    n = 0;
    dropped = wrap_q;
    // least significant digit first; leading digits past the cap are dropped
    do begin
      if (n < DIGIT_LIMIT) begin
        rem[n] = rc_pkg::DIGIT_W'(rest % ob);
        n++;
      end else begin
        dropped = 1'b1;
      end
      rest = rest / ob;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (rem[k] < rc_pkg::TEN) begin
        od.code = rc_pkg::CHAR_ZERO + rc_pkg::CHAR_W'(rem[k]);
      end else begin
        od.code = rc_pkg::CHAR_A + rc_pkg::CHAR_W'(rem[k]) - rc_pkg::TEN;
      end
      od.last_digit = (k == 0);
      od.overflow = dropped;
      digits_due.push_back(od);
    end
    acc_q = '0;
    wrap_q = 1'b0;
  endfunction

  task automatic push_char(input logic [rc_pkg::CHAR_W-1:0] c, input logic lst);
    char_item_t it;
    it.code = c;
    it.final_char = lst;
    char_queue.push_back(it);
    items_queued++;
    chars_pending++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Mostly legal digits for the current base, with occasional arbitrary bytes
  task automatic queue_random_number();
    int                        len;
    int                        ib;
    int                        d;
    logic [rc_pkg::CHAR_W-1:0] c;
    ib = eff_base(in_base_q);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 36) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = rc_pkg::CHAR_W'($urandom_range(0, 255));
      end else begin
        d = $urandom_range(0, ib - 1);
        if (d < rc_pkg::TEN) c = rc_pkg::CHAR_ZERO + rc_pkg::CHAR_W'(d);
        else c = rc_pkg::CHAR_A + rc_pkg::CHAR_W'(d) - rc_pkg::TEN;
      end
      push_char(c, i == len - 1);
    end
  endtask

  function automatic logic [rc_pkg::BASE_W-1:0] pick_base();
    if ($urandom_range(0, 5) == 0) return rc_pkg::BASE_W'($urandom_range(0, 31));
    return rc_pkg::BASE_W'($urandom_range(rc_pkg::BASE_MIN, rc_pkg::BASE_MAX));
  endfunction

  // Write one base register; the caller sits on a falling edge
  task automatic write_reg(input logic idx, input logic [rc_pkg::BASE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == rc_pkg::CFG_IN_BASE) in_base_q = val;
    else out_base_q = val;
    @(negedge clk);
  endtask

  // Wait until every character is taken and every digit has come back
  task automatic drain();
    while (chars_pending != 0 || digits_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Drive characters in bursts with random gaps; hold an item until its transaction
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left != 0 || char_queue.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_item = char_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_item.code;
        in_tlast <= next_item.final_char;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Stall the result side: ready always high, random or mostly low by mode, plus one long hold-off
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 100 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && out_beats >= HOLD_AFTER_BEATS) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        fold_and_convert(in_tdata, in_tlast);
        chars_pending--;
      end
      if (out_tvalid && out_tready) begin
        out_beats++;
        if (digits_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected digit: expected none, actual char %h last %b ovf %b",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          want = digits_due.pop_front();
          if (out_tdata !== want.code || out_tlast !== want.last_digit ||
              out_tuser !== want.overflow) begin
            errors++;
            $display("%0t: digit mismatch: expected char %h last %b ovf %b, actual char %h last %b ovf %b",
                     $time, want.code, want.last_digit, want.overflow,
                     out_tdata, out_tlast, out_tuser);
          end
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset bases: zero value, most negative digit, largest digit byte
    queue_text("0");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    drain();

    // Hex in, binary out: widest digit count, then wrap past the value width
    write_reg(rc_pkg::CFG_IN_BASE, 16);
    write_reg(rc_pkg::CFG_OUT_BASE, 2);
    queue_text("FFFFFFFF");
    repeat (7) push_char("F", 1'b0);
    push_char(8'hFF, 1'b1);
    drain();

    // Bases below range saturate low, above range saturate high
    write_reg(rc_pkg::CFG_IN_BASE, 0);
    write_reg(rc_pkg::CFG_OUT_BASE, 31);
    queue_text("101");
    queue_text("9");
    drain();
    write_reg(rc_pkg::CFG_IN_BASE, 31);
    write_reg(rc_pkg::CFG_OUT_BASE, 1);
    queue_text("Fz");
    drain();

    // Random phases: new bases, then a handful of numbers
    while (items_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      write_reg(rc_pkg::CFG_IN_BASE, pick_base());
      write_reg(rc_pkg::CFG_OUT_BASE, pick_base());
      repeat (6) queue_random_number();
      drain();
    end

    repeat (40) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
